>>> sv/imh_pkg.sv
// ----------------------------------------------------------------------------
// imh_pkg: shared types and constants of the indexed min-heap
// Request and response payloads, status codes, modes and the
// controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package imh_pkg;

   localparam int CAPACITY   = 256;
   localparam int KEY_BITS   = 32;
   localparam int HANDLES    = 256;
   localparam int SLOT_W     = $clog2(CAPACITY);
   localparam int COUNT_W    = $clog2(CAPACITY + 1);
   localparam int HANDLE_W   = 8;
   localparam int OUT_KEY_W  = 32;

   typedef logic [1:0] mode_type;
   localparam mode_type MODE_INSERT = 2'd0;
   localparam mode_type MODE_REMOVE = 2'd1;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_FULL    = 2'd1;
   localparam status_type ST_ABSENT  = 2'd2;
   localparam status_type ST_PRESENT = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  handle_id;
      logic [31:0] sort_key;
   } req_type;

   typedef struct packed {
      logic [7:0]  min_handle;
      logic [31:0] min_key;
      logic        heap_empty;
      logic [8:0]  entry_total;
      logic [1:0]  status;
   } rsp_type;

   // Datapath operation codes issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,      // capture request, read flag/position of handle
      OP_INSERT,     // write new entry at last slot
      OP_REMOVE,     // clear flag, decrement, read handle of last slot
      OP_RD_CUR,     // read handle at cur slot
      OP_RD_PAR,     // read handle at parent / left child
      OP_RD_RGT,     // read handle at right child
      OP_KEYS,       // keys of cur and other handle(s) are registered
      OP_SWAP_A,     // write cur slot with other handle
      OP_SWAP_B,     // write other slot with cur handle, move cur
      OP_RD_TOP,     // read slot 0
      OP_RD_TKEY,    // read key of top
      OP_FILL        // write the moved last-slot handle into the hole
   } op_type;

   typedef struct packed {
      op_type op;
      logic   use_right;  // swap target is the right child
      logic   go_down;    // sifting downwards: other slot is the left child
   } dp_cmd_type;

   typedef struct packed {
      logic present;      // present flag of request handle
      logic full;
      logic cnt_zero;
      logic hole_last;    // removed slot is the last slot
      logic cur_root;     // cur slot is 0
      logic has_left;
      logic has_right;
      logic lt_par;       // key(cur) < key(other)
      logic rgt_lt_best;  // key(right) < min(key(cur), key(left))
      logic left_lt_cur;
   } dp_stat_type;

endpackage

>>> sv/indexed_min_heap.sv
// ----------------------------------------------------------------------------
// indexed_min_heap: indexed binary min-heap with handle position table
// Insert, remove-by-handle and query; reports minimum, count and status.
// ----------------------------------------------------------------------------
// From acceptance to response strobe: a request is checked; an insert then writes
// the last slot and sifts up, a removal fills the hole (unless it was the last slot)
// and sifts up or down, one read-compare-swap pass per level; then the top is read.
// One transaction at a time: busy falls after the strobe cycle, and a new start is
// taken once busy is low; the receiver cannot stall.
// Synchronous reset clears presence flags and the count; memories are not reset.
module indexed_min_heap (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  imh_pkg::req_type  req_data,
   output logic              rsp_valid,
   output imh_pkg::rsp_type  rsp_data
);
   import imh_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;
   rsp_type     top;
   status_type  status;
   logic        fire;

   imh_control u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_data.mode),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy),
      .rsp_fire (fire),
      .status   (status)
   );

   imh_datapath u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_in  (req_data),
      .cmd     (cmd),
      .stat    (stat),
      .top_out (top)
   );

   always_comb begin
      rsp_valid       = fire;
      rsp_data        = top;
      rsp_data.status = status;
   end

endmodule

>>> sv/imh_datapath.sv
// ----------------------------------------------------------------------------
// imh_datapath: heap memories, position table and compare logic
// Executes one controller command per cycle; memory reads are registered.
// ----------------------------------------------------------------------------
module imh_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  imh_pkg::req_type     req_in,
   input  imh_pkg::dp_cmd_type  cmd,
   output imh_pkg::dp_stat_type stat,
   output imh_pkg::rsp_type     top_out
);
   import imh_pkg::*;

   // memories
   logic [HANDLE_W-1:0] heap_mem [CAPACITY];
   logic [KEY_BITS-1:0] key_mem  [HANDLES];
   logic [SLOT_W-1:0]   pos_mem  [HANDLES];
   logic [HANDLES-1:0]  present_ff;

   req_type             req_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [SLOT_W-1:0]   cur_ff, oth_ff;
   logic [HANDLE_W-1:0] hcur_ff, hoth_ff, hrgt_ff, htop_ff;
   logic [KEY_BITS-1:0] kcur_ff, koth_ff, krgt_ff, ktop_ff;
   logic [SLOT_W-1:0]   hpos_ff;

   logic [COUNT_W-1:0]  cur_w, left_w, right_w;
   logic [SLOT_W-1:0]   par_w;
   logic [SLOT_W-1:0]   oth_sel_w;
   logic [COUNT_W-1:0]  last_w;

   // heap arithmetic on the current slot
   assign cur_w   = COUNT_W'(cur_ff);
   assign left_w  = COUNT_W'({cur_ff, 1'b1});
   assign right_w = COUNT_W'({cur_ff, 1'b0}) + COUNT_W'(2);
   assign par_w   = SLOT_W'((cur_w - COUNT_W'(1)) >> 1);
   assign last_w  = count_ff - COUNT_W'(1);
   // compare partner: left child when sifting down or at the root, else parent
   assign oth_sel_w = (cmd.go_down || stat.cur_root) ? SLOT_W'(left_w) : par_w;

   always_comb begin
      logic [KEY_BITS-1:0] best_k;
      stat.present     = present_ff[req_ff.handle_id];
      stat.full        = (count_ff >= COUNT_W'(CAPACITY));
      stat.cnt_zero    = (count_ff == '0);
      stat.hole_last   = (COUNT_W'(hpos_ff) == count_ff);
      stat.cur_root    = (cur_ff == '0);
      stat.has_left    = (left_w < count_ff) && (cur_w < COUNT_W'(CAPACITY / 2));
      stat.has_right   = (right_w < count_ff) && (cur_w < COUNT_W'(CAPACITY / 2));
      stat.lt_par      = (kcur_ff < koth_ff);
      stat.left_lt_cur = stat.has_left && (koth_ff < kcur_ff);
      best_k = (stat.left_lt_cur) ? koth_ff : kcur_ff;
      stat.rgt_lt_best = stat.has_right && (krgt_ff < best_k);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
         count_ff   <= '0;
      end else begin
         case (cmd.op)
            OP_INSERT: begin
               present_ff[req_ff.handle_id] <= 1'b1;
               count_ff <= count_ff + COUNT_W'(1);
            end
            OP_REMOVE: begin
               present_ff[req_ff.handle_id] <= 1'b0;
               count_ff <= last_w;
            end
            default: ;
         endcase
      end
   end

   // memories and payload registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LATCH: begin
            req_ff  <= req_in;
         end
         OP_INSERT: begin
            heap_mem[count_ff[SLOT_W-1:0]] <= req_ff.handle_id;
            pos_mem[req_ff.handle_id] <= count_ff[SLOT_W-1:0];
            key_mem[req_ff.handle_id] <= req_ff.sort_key[KEY_BITS-1:0];
            cur_ff  <= count_ff[SLOT_W-1:0];
         end
         OP_REMOVE: begin
            cur_ff <= hpos_ff;
            hcur_ff <= heap_mem[last_w[SLOT_W-1:0]];
         end
         OP_FILL: begin
            heap_mem[cur_ff] <= hcur_ff;
            pos_mem[hcur_ff] <= cur_ff;
         end
         OP_RD_CUR: begin
            // handle now held at the cur slot
            hcur_ff <= heap_mem[cur_ff];
         end
         OP_RD_PAR: begin
            oth_ff  <= oth_sel_w;
            hoth_ff <= heap_mem[oth_sel_w];
            kcur_ff <= key_mem[hcur_ff];
         end
         OP_RD_RGT: begin
            hrgt_ff <= heap_mem[SLOT_W'(right_w)];
            koth_ff <= key_mem[hoth_ff];
         end
         OP_KEYS: begin
            krgt_ff <= key_mem[hrgt_ff];
         end
         OP_SWAP_A: begin
            heap_mem[cur_ff] <= cmd.use_right ? hrgt_ff : hoth_ff;
            pos_mem[cmd.use_right ? hrgt_ff : hoth_ff] <= cur_ff;
            if (cmd.use_right) begin
               oth_ff <= SLOT_W'(right_w);
            end
         end
         OP_SWAP_B: begin
            heap_mem[oth_ff] <= hcur_ff;
            pos_mem[hcur_ff] <= oth_ff;
            cur_ff <= oth_ff;
         end
         OP_RD_TOP: begin
            htop_ff <= heap_mem[0];
         end
         OP_RD_TKEY: begin
            ktop_ff <= key_mem[htop_ff];
         end
         default: ;
      endcase
      // position of request handle, read the cycle after latch
      hpos_ff <= pos_mem[req_ff.handle_id];
   end

   always_comb begin
      top_out.min_handle  = stat.cnt_zero ? '0 : htop_ff;
      top_out.min_key     = stat.cnt_zero ? '0 : OUT_KEY_W'(ktop_ff);
      top_out.heap_empty  = stat.cnt_zero;
      top_out.entry_total = 9'(count_ff);
      top_out.status      = ST_OK;
   end

endmodule

>>> sv/imh_control.sv
// ----------------------------------------------------------------------------
// imh_control: sequencer for insert, remove and sift operations
// Walks the heap one level per pass, issuing datapath commands.
// ----------------------------------------------------------------------------
module imh_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  imh_pkg::mode_type    req_mode,
   input  imh_pkg::dp_stat_type stat,
   output imh_pkg::dp_cmd_type  cmd,
   output logic                 busy,
   output logic                 rsp_fire,
   output imh_pkg::status_type  status
);
   import imh_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_CHECK, S_CHECK2, S_INS, S_RM, S_RMW, S_CUR, S_PAR, S_RGT,
      S_KEYS, S_DEC, S_SWA, S_SWB, S_TOP, S_TKEY, S_RSP
   } state_type;

   state_type  state_ff;
   mode_type   mode_ff;
   status_type status_ff;
   logic       down_ff;    // sifting downwards
   logic       first_ff;   // first compare after a removal
   logic       right_ff;

   assign busy   = (state_ff != S_IDLE);
   assign status = status_ff;
   assign rsp_fire = (state_ff == S_RSP);

   always_comb begin
      cmd.use_right = right_ff;
      cmd.go_down   = down_ff;
      case (state_ff)
         S_IDLE:  cmd.op = start ? OP_LATCH : OP_NONE;
         S_INS:   cmd.op = OP_INSERT;
         S_RM:    cmd.op = OP_REMOVE;
         S_RMW:   cmd.op = OP_FILL;
         S_CUR:   cmd.op = OP_RD_CUR;
         S_PAR:   cmd.op = OP_RD_PAR;
         S_RGT:   cmd.op = OP_RD_RGT;
         S_KEYS:  cmd.op = OP_KEYS;
         S_SWA:   cmd.op = OP_SWAP_A;
         S_SWB:   cmd.op = OP_SWAP_B;
         S_TOP:   cmd.op = OP_RD_TOP;
         S_TKEY:  cmd.op = OP_RD_TKEY;
         default: cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         mode_ff   <= MODE_INSERT;
         status_ff <= ST_OK;
         down_ff   <= 1'b0;
         first_ff  <= 1'b0;
         right_ff  <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  mode_ff   <= req_mode;
                  status_ff <= ST_OK;
                  state_ff  <= S_CHECK;
               end
            end
            S_CHECK: begin
               // position table read lands next cycle
               state_ff <= S_CHECK2;
            end
            S_CHECK2: begin
               down_ff <= 1'b0;
               right_ff <= 1'b0;
               if (mode_ff == MODE_INSERT) begin
                  if (stat.present) begin
                     status_ff <= ST_PRESENT;
                     state_ff  <= S_TOP;
                  end else if (stat.full) begin
                     status_ff <= ST_FULL;
                     state_ff  <= S_TOP;
                  end else begin
                     first_ff <= 1'b0;
                     state_ff <= S_INS;
                  end
               end else if (mode_ff == MODE_REMOVE) begin
                  if (!stat.present || stat.cnt_zero) begin
                     status_ff <= ST_ABSENT;
                     state_ff  <= S_TOP;
                  end else begin
                     first_ff <= 1'b1;
                     state_ff <= S_RM;
                  end
               end else begin
                  state_ff <= S_TOP;
               end
            end
            S_INS: state_ff <= S_CUR;
            S_RM: begin
               // count already decremented next cycle; hole_last compares to new count
               state_ff <= S_RMW;
            end
            S_RMW: state_ff <= stat.hole_last ? S_TOP : S_CUR;
            S_CUR: state_ff <= S_PAR;
            S_PAR: begin
               // up: other=parent (left child at the root); down: other=left child
               state_ff <= S_RGT;
            end
            S_RGT: state_ff <= S_KEYS;
            S_KEYS: state_ff <= S_DEC;
            S_DEC: begin
               if (!down_ff && !stat.cur_root && stat.lt_par) begin
                  // rises: swap with parent
                  first_ff <= 1'b0;
                  right_ff <= 1'b0;
                  state_ff <= S_SWA;
               end else if (!down_ff && !first_ff) begin
                  right_ff <= 1'b0;
                  state_ff <= S_TOP;
               end else if (!down_ff && !stat.cur_root) begin
                  // removal that did not rise: re-read with left child
                  down_ff  <= 1'b1;
                  first_ff <= 1'b0;
                  right_ff <= 1'b0;
                  state_ff <= S_CUR;
               end else begin
                  // downward step
                  down_ff  <= 1'b1;
                  first_ff <= 1'b0;
                  right_ff <= stat.rgt_lt_best;
                  if (stat.rgt_lt_best || stat.left_lt_cur) begin
                     state_ff <= S_SWA;
                  end else begin
                     state_ff <= S_TOP;
                  end
               end
            end
            S_SWA: state_ff <= S_SWB;
            S_SWB: state_ff <= S_CUR;
            S_TOP: state_ff <= S_TKEY;
            S_TKEY: state_ff <= S_RSP;
            S_RSP: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("start not taken");
   a_rsp_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |=> !rsp_fire) else $error("response held");
   a_rsp_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |=> !busy) else $error("not idle after response");
`endif

endmodule

>>> dv/indexed_min_heap_tb.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_tb: self-checking bench for the indexed min-heap
// Drives insert, remove and query transactions through start/busy. An
// in-bench heap model predicts each response not typed in the directed table,
// and every response strobe is checked field by field. The directed table runs
// first, then random traffic in several idling phases, including a full fill and drain.
// ----------------------------------------------------------------------------
module indexed_min_heap_tb;
   import imh_pkg::*;

   localparam mode_type MODE_QUERY = 2'd2;
   localparam mode_type MODE_SPARE = 2'd3;   // behaves as a query
   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 120;

   typedef struct {
      req_type r;
      bit      fixed;
      rsp_type rsp;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   // in-bench heap model
   bit [7:0]  hp_slot [256];
   bit [31:0] hp_key  [256];
   bit [7:0]  hp_pos  [256];
   bit        hp_here [256];
   int        hp_count;

   // per-transaction bookkeeping
   stim_row_type row_q[$];
   rsp_type      rsp_due_q[$];
   int           n_fail;
   int           n_sent;
   int           n_checked;
   int           n_full_seen;
   longint       cycle_count;

   indexed_min_heap u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Heap model
   // ------------------------------------------------------------------
   function automatic bit slot_lt(int a, int b);
      return hp_key[hp_slot[a]] < hp_key[hp_slot[b]];
   endfunction

   function automatic void slot_swap(int a, int b);
      bit [7:0] ha;
      bit [7:0] hb;
      ha = hp_slot[a];
      hb = hp_slot[b];
      hp_slot[a] = hb;
      hp_slot[b] = ha;
      hp_pos[hb] = 8'(a);
      hp_pos[ha] = 8'(b);
   endfunction

   function automatic void bubble_up(int p);
      int par;
      while (p > 0) begin
         par = (p - 1) / 2;
         if (!slot_lt(p, par)) break;
         slot_swap(p, par);
         p = par;
      end
   endfunction

   function automatic void bubble_down(int p);
      int best;
      int l;
      int r;
      forever begin
         best = p;
         l = p * 2 + 1;
         r = p * 2 + 2;
         if (l < hp_count && slot_lt(l, best)) best = l;
         if (r < hp_count && slot_lt(r, best)) best = r;
         if (best == p) break;
         slot_swap(p, best);
         p = best;
      end
   endfunction

   function automatic void reheap(int p);
      if (p > 0 && slot_lt(p, (p - 1) / 2)) bubble_up(p);
      else bubble_down(p);
   endfunction

   function automatic rsp_type heap_apply(req_type r);
      rsp_type  o;
      bit [7:0] h;
      int       p;
      status_type st;
      h  = r.handle_id;
      st = ST_OK;
      if (r.mode == MODE_INSERT) begin
         if (hp_here[h]) st = ST_PRESENT;
         else if (hp_count >= CAPACITY) st = ST_FULL;
         else begin
            hp_slot[hp_count] = h;
            hp_pos[h] = 8'(hp_count);
            hp_key[h] = r.sort_key;
            hp_here[h] = 1'b1;
            hp_count++;
            reheap(hp_count - 1);
         end
      end else if (r.mode == MODE_REMOVE) begin
         if (!hp_here[h] || hp_count == 0) st = ST_ABSENT;
         else begin
            p = hp_pos[h];
            hp_here[h] = 1'b0;
            hp_count--;
            // removing the last slot only shrinks the heap
            if (p < hp_count) begin
               hp_slot[p] = hp_slot[hp_count];
               hp_pos[hp_slot[p]] = 8'(p);
               reheap(p);
            end
         end
      end
      o = '0;
      if (hp_count == 0) o.heap_empty = 1'b1;
      else begin
         o.min_handle = hp_slot[0];
         o.min_key    = hp_key[hp_slot[0]];
      end
      o.entry_total = 9'(hp_count);
      o.status      = st;
      return o;
   endfunction

   // ------------------------------------------------------------------
   // Monitor: predict on acceptance, check on strobe
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      stim_row_type row;
      rsp_type      pred;
      rsp_type      want;
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         if (start && !busy) begin
            row  = row_q.pop_front();
            pred = heap_apply(req_data);
            if (pred.status == ST_FULL) n_full_seen++;
            rsp_due_q.insert(rsp_due_q.size(), row.fixed ? row.rsp : pred);
         end
         if (rsp_valid) begin
            if (rsp_due_q.size() == 0) begin
               $error("response with none outstanding: %p", rsp_data);
               n_fail++;
            end else begin
               want = rsp_due_q.pop_front();
               n_checked++;
               if (rsp_data.min_handle !== want.min_handle) begin
                  $error("min_handle exp %0d got %0d", want.min_handle, rsp_data.min_handle);
                  n_fail++;
               end
               if (rsp_data.min_key !== want.min_key) begin
                  $error("min_key exp %0h got %0h", want.min_key, rsp_data.min_key);
                  n_fail++;
               end
               if (rsp_data.heap_empty !== want.heap_empty) begin
                  $error("heap_empty exp %0d got %0d", want.heap_empty, rsp_data.heap_empty);
                  n_fail++;
               end
               if (rsp_data.entry_total !== want.entry_total) begin
                  $error("entry_total exp %0d got %0d", want.entry_total,
                         rsp_data.entry_total);
                  n_fail++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status exp %0d got %0d", want.status, rsp_data.status);
                  n_fail++;
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Driver
   // ------------------------------------------------------------------
   task automatic send(input req_type r, input bit fixed, input rsp_type rsp,
                       input int idle_pct);
      stim_row_type row;
      row.r = r;
      row.fixed = fixed;
      row.rsp = rsp;
      row_q.insert(row_q.size(), row);
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      n_sent++;
      // optional gap after the transaction is taken
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   function automatic req_type mk(mode_type m, int h, bit [31:0] k);
      req_type r;
      r.mode = m;
      r.handle_id = 8'(h);
      r.sort_key = k;
      return r;
   endfunction

   function automatic rsp_type mk_rsp(int h, bit [31:0] k, bit e, int n, status_type s);
      rsp_type o;
      o.min_handle = 8'(h);
      o.min_key = k;
      o.heap_empty = e;
      o.entry_total = 9'(n);
      o.status = s;
      return o;
   endfunction

   function automatic bit [31:0] rand_key();
      case ($urandom_range(4))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(7);           // dense keys give ties
         default: return $urandom;
      endcase
   endfunction

   // pick a handle currently held, or any handle when the heap is empty
   function automatic int held_handle();
      int h;
      h = $urandom_range(255);
      if (hp_count == 0) return h;
      repeat (512) begin
         if (hp_here[h]) return h;
         h = $urandom_range(255);
      end
      return h;
   endfunction

   task automatic random_mix(input int n, input int idle_pct);
      int       sel;
      int       pool;
      req_type  r;
      pool = 15;
      for (int i = 0; i < n; i++) begin
         if (i % 40 == 0) pool = ($urandom_range(1)) ? 15 : 255;
         sel = $urandom_range(99);
         if (sel < 50)
            r = mk(MODE_INSERT, $urandom_range(pool), rand_key());
         else if (sel < 85)
            r = mk(MODE_REMOVE, ($urandom_range(4) == 0) ? $urandom_range(255)
                                                        : held_handle(), 0);
         else
            r = mk(($urandom_range(1)) ? MODE_QUERY : MODE_SPARE, $urandom_range(255),
                   $urandom);
         send(r, 1'b0, '0, idle_pct);
      end
   endtask

   // fill to capacity, try a duplicate insert, then drain in random order
   task automatic fill_and_drain(input int idle_pct);
      for (int h = 0; h < 256; h++)
         send(mk(MODE_INSERT, h ^ 8'hA5, rand_key()), 1'b0, '0, idle_pct);
      send(mk(MODE_INSERT, 8'hA5, 32'h1), 1'b0, '0, idle_pct);
      for (int k = 0; k < 260; k++)
         send(mk(MODE_REMOVE, held_handle(), 0), 1'b0, '0, idle_pct);
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      stim_row_type dir_tbl[$];
      int           wait_cnt;

      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      n_fail = 0;
      n_sent = 0;
      n_checked = 0;
      n_full_seen = 0;
      cycle_count = 0;
      hp_count = 0;
      foreach (hp_here[i]) hp_here[i] = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: typed responses where obvious, model elsewhere
      dir_tbl = '{
         '{mk(MODE_QUERY, 0, 0),                 1, mk_rsp(0, 0, 1, 0, ST_OK)},
         '{mk(MODE_REMOVE, 8'hFF, 0),            1, mk_rsp(0, 0, 1, 0, ST_ABSENT)},
         '{mk(MODE_INSERT, 8'hFF, 32'hFFFF_FFFF), 1, mk_rsp(255, 32'hFFFF_FFFF, 0, 1, ST_OK)},
         '{mk(MODE_INSERT, 8'hFF, 32'h0),        1, mk_rsp(255, 32'hFFFF_FFFF, 0, 1, ST_PRESENT)},
         '{mk(MODE_INSERT, 8'h00, 32'h0),        1, mk_rsp(0, 0, 0, 2, ST_OK)},
         '{mk(MODE_SPARE, 8'hAA, 32'h5555_5555), 1, mk_rsp(0, 0, 0, 2, ST_OK)},
         '{mk(MODE_INSERT, 8'h55, 32'h0),        0, '0},   // equal key, no swap
         '{mk(MODE_INSERT, 8'hAA, 32'h8000_0000), 0, '0},
         '{mk(MODE_INSERT, 8'h0F, 32'h7FFF_FFFF), 0, '0},
         '{mk(MODE_INSERT, 8'hF0, 32'h0000_0001), 0, '0},
         '{mk(MODE_REMOVE, 8'h00, 0),            0, '0},   // remove the top
         '{mk(MODE_REMOVE, 8'hF0, 0),            0, '0},
         '{mk(MODE_QUERY, 8'h12, 32'h1234_5678), 0, '0},
         '{mk(MODE_REMOVE, 8'h0F, 0),            0, '0},
         '{mk(MODE_REMOVE, 8'h0F, 0),            0, '0},   // now absent
         '{mk(MODE_INSERT, 8'h01, 32'h3),        0, '0},
         '{mk(MODE_REMOVE, 8'hFF, 0),            0, '0},   // last slot
         '{mk(MODE_REMOVE, 8'hAA, 0),            0, '0},
         '{mk(MODE_REMOVE, 8'h55, 0),            0, '0},
         '{mk(MODE_REMOVE, 8'h01, 0),            1, mk_rsp(0, 0, 1, 0, ST_OK)},
         '{mk(MODE_REMOVE, 8'h00, 0),            1, mk_rsp(0, 0, 1, 0, ST_ABSENT)}
      };
      foreach (dir_tbl[i])
         send(dir_tbl[i].r, dir_tbl[i].fixed, dir_tbl[i].rsp, 0);

      // random phases with varying sender idling
      random_mix(30, 0);
      random_mix(30, 57);
      fill_and_drain(8);
      random_mix(30, 0);
      random_mix(30, 8);
      start <= 1'b0;

      // let outstanding responses land, then a short quiet period
      wait_cnt = 0;
      while ((rsp_due_q.size() != 0 || row_q.size() != 0) && wait_cnt < 10000) begin
         @(posedge clock);
         wait_cnt++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (rsp_due_q.size() != 0) begin
         $error("%0d responses never arrived", rsp_due_q.size());
         n_fail++;
      end

      $display("sent %0d transactions, checked %0d responses, full rejections %0d",
               n_sent, n_checked, n_full_seen);
      $display("covered directed corners, random mixes and a fill to capacity");
      if (n_fail == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
